@@ rtl/core/agpc_pkg.sv @@
package agpc_pkg;

   // Width of the result columns and positions on the response channel
   localparam int OUT_W = 13;

   // Alignment characters
   localparam logic [7:0] GAP_CHAR = 8'h2D;
   localparam logic [7:0] UPPER_N  = 8'h4E;
   localparam logic [7:0] LOWER_N  = 8'h6E;

   // Register reset values
   localparam logic [7:0] NEAR_WINDOW_RST = 8'd10;
   localparam logic [7:0] EDGE_MARGIN_RST = 8'd4;

   // Register index, taken from paddr[2]
   localparam logic REG_NEAR_WINDOW = 1'b0;
   localparam logic REG_EDGE_MARGIN = 1'b1;

   // Verdict reason codes
   typedef enum logic [2:0] {
      RSN_OK          = 3'd0,
      RSN_N_SEEN      = 3'd1,
      RSN_GAP_SHAPE   = 3'd2,
      RSN_EDGE        = 3'd3,
      RSN_ROWS_DIFFER = 3'd4,
      RSN_NEAR_GAP    = 3'd5,
      RSN_OVERFLOW    = 3'd6
   } reason_type;

endpackage

@@ rtl/core/agpc_ram.sv @@
module agpc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/alignment_gap_pattern_check.sv @@
// Alignment gap pattern check.
// req_*: one alignment column per word (reference, species 1..3 characters
//   and a last-column mark). Columns that are all '-' are dropped; the rest
//   are stored (one flag bit each) and fed to the gap, N and row checks.
// rsp_*: one verdict word per exon, produced after the word marked last:
//   pass flag, reason code, gap start, first column after the gap and the
//   number of stored columns.
// psel/penable/...: register port, near_window at 0x0, edge_margin at 0x4.
// Throughput: a column word that is not last is taken every cycle.
// After the last column DECIDE applies the checks; only if every other
//   check passed and the window is not empty, WALK reads the flag memory
//   (registered read port) one column per cycle across the window around
//   the gap (at most gap span plus twice near_window columns) up to a
//   flagged one. req_stall stays high until EMIT loads the result register.
// The result register frees the input side: new columns stream in while a
//   verdict waits on rsp_stall; only the next verdict waits for it.
// Reset clears the exon state and loads the register defaults. The flag
//   memory is not cleared; it is only read at columns of the current exon.
module alignment_gap_pattern_check #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // column input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_ref_char,
   input  logic [7:0]                         req_first_char,
   input  logic [7:0]                         req_second_char,
   input  logic [7:0]                         req_third_char,
   input  logic                               req_last_column,
   // verdict output
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_accepted,
   output logic [2:0]                         rsp_reason,
   output logic signed [agpc_pkg::OUT_W-1:0]  rsp_gap_begin,
   output logic signed [agpc_pkg::OUT_W-1:0]  rsp_gap_after,
   output logic [agpc_pkg::OUT_W-1:0]         rsp_column_total,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   import agpc_pkg::*;

   localparam int ADDR_W = $clog2(MAX_COLUMNS);
   localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
   localparam int GC_W   = CNT_W + 1;
   localparam int WIN_W  = ((CNT_W > 9) ? CNT_W : 9) + 2;
   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_COLUMNS);

   typedef enum logic [1:0] {
      ST_STREAM,
      ST_DECIDE,
      ST_WALK,
      ST_EMIT
   } state_type;

   function automatic logic is_n(input logic [7:0] ch);
      return (ch == UPPER_N) || (ch == LOWER_N);
   endfunction

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   logic [7:0] near_window_ff, edge_margin_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_window_ff <= NEAR_WINDOW_RST;
         edge_margin_ff <= EDGE_MARGIN_RST;
      end else if (csr_write) begin
         case (paddr[2])
            REG_NEAR_WINDOW: near_window_ff <= pwdata[7:0];
            REG_EDGE_MARGIN: edge_margin_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_NEAR_WINDOW: prdata = {24'd0, near_window_ff};
         REG_EDGE_MARGIN: prdata = {24'd0, edge_margin_ff};
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Column decode
   // ---------------------------------------------------------------
   state_type state_ff, state_in;
   logic      col_accept, all_gap, col_store, col_overflow, n_hit, track;
   logic      ref_gap, first_gap, second_gap, third_gap;
   logic      load_rsp;

   assign req_stall  = (state_ff != ST_STREAM);
   assign col_accept = req_valid & ~req_stall;

   assign ref_gap    = (req_ref_char == GAP_CHAR);
   assign first_gap  = (req_first_char == GAP_CHAR);
   assign second_gap = (req_second_char == GAP_CHAR);
   assign third_gap  = (req_third_char == GAP_CHAR);
   assign all_gap    = ref_gap & first_gap & second_gap & third_gap;
   assign n_hit      = is_n(req_ref_char) | is_n(req_second_char);

   // exon state
   logic [CNT_W-1:0]       column_count_ff, column_count_in;
   logic                   prev_ref_ff, prev_ref_in;
   logic                   prev_second_ff, prev_second_in;
   logic                   have_prev_ff, have_prev_in;
   logic [1:0]             gap_runs_ff, gap_runs_in;
   logic [1:0]             gap_len_ff, gap_len_in;
   logic signed [GC_W-1:0] gap_start_ff, gap_start_in;
   logic signed [GC_W-1:0] gap_end_ff, gap_end_in;
   logic                   n_seen_ff, n_seen_in;
   logic                   differ_ff, differ_in;
   logic                   overflow_ff, overflow_in;
   logic signed [GC_W-1:0] col_pos;
   logic                   gap_row, prev_of_gap, run_ends;

   assign col_store    = col_accept & ~all_gap & (column_count_ff != CAPACITY);
   assign col_overflow = col_accept & ~all_gap & (column_count_ff == CAPACITY);
   assign track        = col_store & ~n_seen_ff & ~n_hit & ~(ref_gap & second_gap);
   assign col_pos      = $signed({1'b0, column_count_ff});
   assign gap_row      = ref_gap | second_gap;
   assign prev_of_gap  = ref_gap ? prev_ref_ff : prev_second_ff;
   assign run_ends     = (~ref_gap & have_prev_ff & prev_ref_ff) |
                         (~second_gap & have_prev_ff & prev_second_ff);

   // Gap tracking between reference and species 2 (never both gapped here)
   always_comb begin
      column_count_in = column_count_ff;
      prev_ref_in     = prev_ref_ff;
      prev_second_in  = prev_second_ff;
      have_prev_in    = have_prev_ff;
      gap_runs_in     = gap_runs_ff;
      gap_len_in      = gap_len_ff;
      gap_start_in    = gap_start_ff;
      gap_end_in      = gap_end_ff;
      n_seen_in       = n_seen_ff;
      differ_in       = differ_ff;
      overflow_in     = overflow_ff;

      if (col_overflow) begin
         overflow_in = 1'b1;
      end
      if (col_store) begin
         column_count_in = column_count_ff + 1'b1;
         if (second_gap != third_gap) begin
            differ_in = 1'b1;
         end
         if (!n_seen_ff && n_hit) begin
            n_seen_in = 1'b1;
         end
      end
      if (track) begin
         if (gap_row) begin
            gap_len_in = (gap_len_ff == 2'd2) ? 2'd0 : gap_len_ff + 2'd1;
            if (!have_prev_ff || !prev_of_gap) begin
               gap_start_in = col_pos;
               if (gap_runs_ff != 2'd2) begin
                  gap_runs_in = gap_runs_ff + 2'd1;
               end
            end
         end
         if (run_ends) begin
            gap_end_in = col_pos;
         end
         prev_ref_in    = ref_gap;
         prev_second_in = second_gap;
         have_prev_in   = 1'b1;
      end

      // verdict loaded into the result register: back to an empty exon
      if (load_rsp) begin
         column_count_in = '0;
         prev_ref_in     = 1'b0;
         prev_second_in  = 1'b0;
         have_prev_in    = 1'b0;
         gap_runs_in     = '0;
         gap_len_in      = '0;
         gap_start_in    = '1;
         gap_end_in      = '1;
         n_seen_in       = 1'b0;
         differ_in       = 1'b0;
         overflow_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         prev_ref_ff     <= 1'b0;
         prev_second_ff  <= 1'b0;
         have_prev_ff    <= 1'b0;
         gap_runs_ff     <= '0;
         gap_len_ff      <= '0;
         gap_start_ff    <= '1;
         gap_end_ff      <= '1;
         n_seen_ff       <= 1'b0;
         differ_ff       <= 1'b0;
         overflow_ff     <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         prev_ref_ff     <= prev_ref_in;
         prev_second_ff  <= prev_second_in;
         have_prev_ff    <= have_prev_in;
         gap_runs_ff     <= gap_runs_in;
         gap_len_ff      <= gap_len_in;
         gap_start_ff    <= gap_start_in;
         gap_end_ff      <= gap_end_in;
         n_seen_ff       <= n_seen_in;
         differ_ff       <= differ_in;
         overflow_ff     <= overflow_in;
      end
   end

   // ---------------------------------------------------------------
   // Flag memory: one bit per stored column, reference xor species 1 gap
   // ---------------------------------------------------------------
   logic              ram_we, ram_wdata, ram_rdata;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] walk_addr_ff, walk_addr_in;

   assign ram_we    = col_store;
   assign ram_waddr = column_count_ff[ADDR_W-1:0];
   assign ram_wdata = ref_gap ^ first_gap;

   agpc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_COLUMNS)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (walk_addr_ff),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------
   // Verdict checks, evaluated in ST_DECIDE
   // ---------------------------------------------------------------
   logic signed [WIN_W-1:0] start_w, end_w, count_w, nw_w, em_w;
   logic signed [WIN_W-1:0] win_lo, win_hi, win_first, win_end, win_last;
   logic                    edge_ok, win_empty;
   reason_type              check_reason;

   assign start_w = WIN_W'(gap_start_ff);
   assign end_w   = WIN_W'(gap_end_ff);
   assign count_w = $signed(WIN_W'(column_count_ff));
   assign nw_w    = $signed(WIN_W'(near_window_ff));
   assign em_w    = $signed(WIN_W'(edge_margin_ff));

   assign edge_ok = (start_w > em_w) && (start_w <= end_w) && (end_w < count_w - em_w);

   always_comb begin
      if (overflow_ff) begin
         check_reason = RSN_OVERFLOW;
      end else if (n_seen_ff) begin
         check_reason = RSN_N_SEEN;
      end else if (gap_runs_ff != 2'd1 || gap_len_ff != 2'd0) begin
         check_reason = RSN_GAP_SHAPE;
      end else if (!edge_ok) begin
         check_reason = RSN_EDGE;
      end else if (differ_ff) begin
         check_reason = RSN_ROWS_DIFFER;
      end else begin
         check_reason = RSN_OK;
      end
   end

   // window around the gap, clipped to the stored columns
   assign win_lo    = start_w - nw_w;
   assign win_hi    = end_w + nw_w;
   assign win_first = (win_lo < 0) ? '0 : win_lo;
   assign win_end   = (win_hi > count_w) ? count_w : win_hi;
   assign win_last  = win_end - WIN_W'(1);
   assign win_empty = (win_first >= win_end);

   // ---------------------------------------------------------------
   // Sequencer: decide, window walk, result register
   // ---------------------------------------------------------------
   reason_type           verdict_ff, verdict_in;
   logic [ADDR_W-1:0]    walk_last_ff, walk_last_in;
   logic                 walk_issue_ff, walk_issue_in;
   logic                 walk_pend_ff, walk_pend_in;
   logic                 walk_pend_last_ff, walk_pend_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_accepted_ff;
   reason_type           rsp_reason_ff;
   logic signed [OUT_W-1:0] rsp_gap_begin_ff, rsp_gap_after_ff;
   logic [OUT_W-1:0]     rsp_column_total_ff;
   logic                 out_free, walk_at_last;

   assign out_free     = ~rsp_valid_ff | ~rsp_stall;
   assign walk_at_last = (walk_addr_ff == walk_last_ff);

   always_comb begin
      state_in          = state_ff;
      verdict_in        = verdict_ff;
      walk_addr_in      = walk_addr_ff;
      walk_last_in      = walk_last_ff;
      walk_issue_in     = walk_issue_ff;
      walk_pend_in      = 1'b0;
      walk_pend_last_in = walk_pend_last_ff;
      load_rsp          = 1'b0;

      case (state_ff)
         ST_STREAM: begin
            if (col_accept && req_last_column) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            verdict_in = check_reason;
            if (check_reason != RSN_OK || win_empty) begin
               state_in = ST_EMIT;
            end else begin
               walk_addr_in  = win_first[ADDR_W-1:0];
               walk_last_in  = win_last[ADDR_W-1:0];
               walk_issue_in = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            // issue one read per cycle up to the window end
            if (walk_issue_ff) begin
               walk_addr_in      = walk_addr_ff + 1'b1;
               walk_pend_in      = 1'b1;
               walk_pend_last_in = walk_at_last;
               walk_issue_in     = ~walk_at_last;
            end
            // check the flag returned by the previous read
            if (walk_pend_ff) begin
               if (ram_rdata) begin
                  verdict_in    = RSN_NEAR_GAP;
                  walk_issue_in = 1'b0;
                  state_in      = ST_EMIT;
               end else if (walk_pend_last_ff) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_STREAM;
            end
         end
         default: state_in = ST_STREAM;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_STREAM;
         walk_issue_ff <= 1'b0;
         walk_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_issue_ff <= walk_issue_in;
         walk_pend_ff  <= walk_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      verdict_ff        <= verdict_in;
      walk_addr_ff      <= walk_addr_in;
      walk_last_ff      <= walk_last_in;
      walk_pend_last_ff <= walk_pend_last_in;
      if (load_rsp) begin
         rsp_accepted_ff     <= (verdict_ff == RSN_OK);
         rsp_reason_ff       <= verdict_ff;
         rsp_gap_begin_ff    <= OUT_W'(gap_start_ff);
         rsp_gap_after_ff    <= OUT_W'(gap_end_ff);
         rsp_column_total_ff <= OUT_W'(column_count_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_reason       = rsp_reason_ff;
   assign rsp_gap_begin    = rsp_gap_begin_ff;
   assign rsp_gap_after    = rsp_gap_after_ff;
   assign rsp_column_total = rsp_column_total_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_pass_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_reason == RSN_OK)))
      else $error("pass flag disagrees with reason code");

   a_no_store_during_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !ram_we)
      else $error("flag memory written during window walk");

   a_exon_cleared: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (column_count_ff == '0 && !overflow_ff && !n_seen_ff))
      else $error("exon state not cleared after verdict");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      column_count_ff <= CAPACITY)
      else $error("column count beyond capacity");

endmodule

@@ dv/agpc_checker.sv @@
module agpc_checker #(
   parameter int CAPACITY = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [7:0]                         req_ref_char,
   input  logic [7:0]                         req_first_char,
   input  logic [7:0]                         req_second_char,
   input  logic [7:0]                         req_third_char,
   input  logic                               req_last_column,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_accepted,
   input  logic [2:0]                         rsp_reason,
   input  logic signed [agpc_pkg::OUT_W-1:0]  rsp_gap_begin,
   input  logic signed [agpc_pkg::OUT_W-1:0]  rsp_gap_after,
   input  logic [agpc_pkg::OUT_W-1:0]         rsp_column_total,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   input  logic [31:0]                        prdata,
   input  logic                               pready,
   output int                                 mismatches,
   output int                                 verdicts_left
);
   timeunit 1ns;
   timeprecision 1ps;

   import agpc_pkg::*;

   typedef struct {
      logic                     accepted;
      reason_type               reason;
      logic signed [OUT_W-1:0]  gap_begin;
      logic signed [OUT_W-1:0]  gap_after;
      logic [OUT_W-1:0]         total;
   } verdict_type;

   // predicted copy of the registers, the flag memory and the exon state
   int          near_cols;
   int          edge_cols;
   bit          flag_mem [CAPACITY];
   int          col_count;
   bit          prev_ref_gap;
   bit          prev_sec_gap;
   bit          have_prev;
   int          run_count;
   int          len_mod3;
   int          gap_start;
   int          gap_end;
   bit          saw_n;
   bit          saw_diff;
   bit          saw_ovf;
   int          verdict_index;
   verdict_type pending_verdicts[$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                              input logic [OUT_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("verdict %0d %s: got %0h, expected %0h",
                                   verdict_index, name, got, want));
   endtask

   function automatic void clear_exon();
      col_count    = 0;
      prev_ref_gap = 1'b0;
      prev_sec_gap = 1'b0;
      have_prev    = 1'b0;
      run_count    = 0;
      len_mod3     = 0;
      gap_start    = -1;
      gap_end      = -1;
      saw_n        = 1'b0;
      saw_diff     = 1'b0;
      saw_ovf      = 1'b0;
   endfunction

   // run start / run end bookkeeping for one row against its previous column
   function automatic void follow_gap(input bit is_gap, input bit was_gap, input int col);
      if (is_gap) begin
         len_mod3 = (len_mod3 + 1) % 3;
         if (!have_prev || !was_gap) begin
            gap_start = col;
            if (run_count < 2) run_count++;
         end
      end else if (have_prev && was_gap) begin
         gap_end = col;
      end
   endfunction

   // any reference/species-1 mismatch flag inside the window around the gap
   function automatic bit window_flagged();
      int lo;
      int hi;
      lo = gap_start - near_cols;
      hi = gap_end + near_cols;
      if (lo < 0) lo = 0;
      if (hi > col_count) hi = col_count;
      for (int i = lo; i < hi; i++) begin
         if (i < CAPACITY && flag_mem[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic take_column(input logic [7:0] r, f, s, t, input logic last);
      bit          rg;
      bit          fg;
      bit          sg;
      bit          tg;
      int          col;
      verdict_type v;
      rg = (r == GAP_CHAR);
      fg = (f == GAP_CHAR);
      sg = (s == GAP_CHAR);
      tg = (t == GAP_CHAR);

      // all-dash columns are dropped
      if (!(rg && fg && sg && tg)) begin
         if (col_count >= CAPACITY) begin
            saw_ovf = 1'b1;
         end else begin
            col = col_count;
            flag_mem[col] = rg ^ fg;
            col_count++;
            if (sg != tg) saw_diff = 1'b1;
            // tracker freezes after the first N; ref+species-2 gap columns skip it
            if (!saw_n) begin
               if (r == UPPER_N || r == LOWER_N || s == UPPER_N || s == LOWER_N) begin
                  saw_n = 1'b1;
               end else if (!(rg && sg)) begin
                  follow_gap(rg, prev_ref_gap, col);
                  follow_gap(sg, prev_sec_gap, col);
                  prev_ref_gap = rg;
                  prev_sec_gap = sg;
                  have_prev    = 1'b1;
               end
            end
         end
      end

      if (last) begin
         // checks in priority order, first failure wins
         if (saw_ovf)
            v.reason = RSN_OVERFLOW;
         else if (saw_n)
            v.reason = RSN_N_SEEN;
         else if (run_count != 1 || len_mod3 != 0)
            v.reason = RSN_GAP_SHAPE;
         else if (!(gap_start > edge_cols && gap_start <= gap_end &&
                    gap_end < col_count - edge_cols))
            v.reason = RSN_EDGE;
         else if (saw_diff)
            v.reason = RSN_ROWS_DIFFER;
         else if (window_flagged())
            v.reason = RSN_NEAR_GAP;
         else
            v.reason = RSN_OK;
         v.accepted  = (v.reason == RSN_OK);
         v.gap_begin = gap_start[OUT_W-1:0];
         v.gap_after = gap_end[OUT_W-1:0];
         v.total     = col_count[OUT_W-1:0];
         pending_verdicts.push_back(v);
         clear_exon();
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         near_cols     = NEAR_WINDOW_RST;
         edge_cols     = EDGE_MARGIN_RST;
         mismatches    = 0;
         verdict_index = 0;
         pending_verdicts.delete();
         clear_exon();
      end else begin
         // verdict word leaving the block
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict %0d arrived with none expected",
                                         verdict_index));
            end else begin
               want = pending_verdicts.pop_front();
               check_field("accepted", OUT_W'(rsp_accepted), OUT_W'(want.accepted));
               check_field("reason", OUT_W'(rsp_reason), OUT_W'(want.reason));
               check_field("gap_begin", rsp_gap_begin, want.gap_begin);
               check_field("gap_after", rsp_gap_after, want.gap_after);
               check_field("column_total", rsp_column_total, want.total);
            end
            verdict_index++;
         end

         // register access
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == REG_EDGE_MARGIN)
                  edge_cols = pwdata[7:0];
               else
                  near_cols = pwdata[7:0];
            end else if (paddr[2] == REG_EDGE_MARGIN) begin
               if (prdata !== {24'd0, 8'(edge_cols)})
                  report_mismatch($sformatf("edge_margin read %0h, expected %0h",
                                            prdata, edge_cols));
            end else begin
               if (prdata !== {24'd0, 8'(near_cols)})
                  report_mismatch($sformatf("near_window read %0h, expected %0h",
                                            prdata, near_cols));
            end
         end

         // column word entering the block
         if (req_valid && !req_stall)
            take_column(req_ref_char, req_first_char, req_second_char, req_third_char,
                        req_last_column);
      end
      verdicts_left <= pending_verdicts.size();
   end

endmodule

@@ dv/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import agpc_pkg::*;

   localparam int COLUMN_CAPACITY = 4096;
   localparam int CYCLE_LIMIT     = 3000000;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 700;
   localparam int PHASE_COLUMNS   = 120;
   localparam int PHASES          = 6;
   localparam logic [7:0] BASES [4] = '{"A", "C", "G", "T"};

   logic                     clock;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_ref_char    = 8'd0;
   logic [7:0]               req_first_char  = 8'd0;
   logic [7:0]               req_second_char = 8'd0;
   logic [7:0]               req_third_char  = 8'd0;
   logic                     req_last_column = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall       = 1'b0;
   logic                     rsp_accepted;
   logic [2:0]               rsp_reason;
   logic signed [OUT_W-1:0]  rsp_gap_begin;
   logic signed [OUT_W-1:0]  rsp_gap_after;
   logic [OUT_W-1:0]         rsp_column_total;
   logic                     psel            = 1'b0;
   logic                     penable         = 1'b0;
   logic                     pwrite          = 1'b0;
   logic [2:0]               paddr           = 3'd0;
   logic [31:0]              pwdata          = 32'd0;
   logic [31:0]              prdata;
   logic                     pready;
   int                       mismatches;
   int                       verdicts_left;

   // stimulus control
   bit         quiet        = 1'b0;
   bit         hold_request = 1'b0;
   logic       hold_rsp     = 1'b0;
   int         stall_left   = 0;
   int         columns_sent = 0;
   int         cycles       = 0;
   logic [7:0] row_ref[$];
   logic [7:0] row_first[$];
   logic [7:0] row_second[$];
   logic [7:0] row_third[$];

   alignment_gap_pattern_check #(.MAX_COLUMNS(COLUMN_CAPACITY)) DUT (.*);

   agpc_checker #(.CAPACITY(COLUMN_CAPACITY)) verdict_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("alignment_gap_pattern_check test failed");
         $finish;
      end
   end

   // verdict receiver: random hold-off after each word, plus the long hold
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            stall_left = quiet ? 0 : $urandom_range(0, 19);
         else if (stall_left != 0)
            stall_left--;
         rsp_stall <= hold_rsp || (stall_left != 0);
      end
   end

   // long receiver hold-off, counted here while columns keep coming
   initial begin
      wait (hold_request);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic send_column(input logic [7:0] r, f, s, t, input logic last);
      int unsigned pause;
      pause = quiet ? 0 : $urandom_range(0, 19);
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_ref_char    <= r;
      req_first_char  <= f;
      req_second_char <= s;
      req_third_char  <= t;
      req_last_column <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic send_rows();
      for (int i = 0; i < row_ref.size(); i++) begin
         send_column(row_ref[i], row_first[i], row_second[i], row_third[i],
                     i == row_ref.size() - 1);
         if (!(row_ref[i] == GAP_CHAR && row_first[i] == GAP_CHAR &&
               row_second[i] == GAP_CHAR && row_third[i] == GAP_CHAR))
            columns_sent++;
      end
   endtask

   task automatic clear_rows();
      row_ref.delete();
      row_first.delete();
      row_second.delete();
      row_third.delete();
   endtask

   task automatic load_rows(input string a, b, c, d);
      clear_rows();
      for (int i = 0; i < a.len(); i++) begin
         row_ref.push_back(a[i]);
         row_first.push_back(b[i]);
         row_second.push_back(c[i]);
         row_third.push_back(d[i]);
      end
   endtask

   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 5))
         0, 1: return 8'($urandom_range(0, 255));
         2: return GAP_CHAR;
         3: return $urandom_range(0, 1) ? UPPER_N : LOWER_N;
         default: return BASES[$urandom_range(0, 3)];
      endcase
   endfunction

   // mostly well-formed exons with occasional defects, some pure noise
   task automatic build_exon();
      int len;
      int glen;
      int gstart;
      int maxk;
      int pos;
      bit gap_in_ref;
      clear_rows();
      if ($urandom_range(0, 3) == 0) begin
         len = $urandom_range(1, 24);
         repeat (len) begin
            row_ref.push_back(noise_char());
            row_first.push_back(noise_char());
            row_second.push_back(noise_char());
            row_third.push_back(noise_char());
         end
      end else begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(4, 30);
         repeat (len) begin
            row_ref.push_back(BASES[$urandom_range(0, 3)]);
            row_first.push_back(BASES[$urandom_range(0, 3)]);
            row_second.push_back(BASES[$urandom_range(0, 3)]);
            row_third.push_back(BASES[$urandom_range(0, 3)]);
         end
         // one gap run of whole codons, in ref/species 1 or in species 2/3
         if ($urandom_range(0, 11) != 0) begin
            maxk = (len - 1) / 3;
            if (maxk > 4) maxk = 4;
            glen = 3 * $urandom_range(1, maxk);
            gstart = $urandom_range(0, len - glen);
            gap_in_ref = $urandom_range(0, 1);
            for (int i = gstart; i < gstart + glen; i++) begin
               if (gap_in_ref) begin
                  row_ref[i]   = GAP_CHAR;
                  row_first[i] = GAP_CHAR;
               end else begin
                  row_second[i] = GAP_CHAR;
                  row_third[i]  = GAP_CHAR;
               end
            end
         end
         // defects
         if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, len - 1);
            if ($urandom_range(0, 1)) row_ref[pos] = $urandom_range(0, 1) ? UPPER_N : LOWER_N;
            else row_second[pos] = $urandom_range(0, 1) ? UPPER_N : LOWER_N;
         end
         if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, len - 1);
            row_third[pos] = (row_third[pos] == GAP_CHAR) ? BASES[0] : GAP_CHAR;
         end
         if ($urandom_range(0, 5) == 0) begin
            pos = $urandom_range(0, len - 1);
            if ($urandom_range(0, 1)) begin
               row_ref[pos]   = GAP_CHAR;
               row_first[pos] = GAP_CHAR;
            end else begin
               row_second[pos] = GAP_CHAR;
               row_third[pos]  = GAP_CHAR;
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, len - 1);
            row_first[pos] = (row_first[pos] == GAP_CHAR) ? BASES[1] : GAP_CHAR;
         end
         if ($urandom_range(0, 11) == 0) begin
            pos = $urandom_range(0, len - 1);
            row_ref[pos]    = GAP_CHAR;
            row_second[pos] = GAP_CHAR;
         end
         if ($urandom_range(0, 11) == 0) begin
            pos = $urandom_range(0, len - 1);
            row_ref[pos]    = GAP_CHAR;
            row_first[pos]  = GAP_CHAR;
            row_second[pos] = GAP_CHAR;
            row_third[pos]  = GAP_CHAR;
         end
         if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, len - 1);
            case ($urandom_range(0, 3))
               0: row_ref[pos]    = 8'($urandom_range(0, 255));
               1: row_first[pos]  = 8'($urandom_range(0, 255));
               2: row_second[pos] = 8'($urandom_range(0, 255));
               default: row_third[pos] = 8'($urandom_range(0, 255));
            endcase
         end
      end
      // closing column of dashes, dropped but still ends the exon
      if ($urandom_range(0, 14) == 0) begin
         row_ref.push_back(GAP_CHAR);
         row_first.push_back(GAP_CHAR);
         row_second.push_back(GAP_CHAR);
         row_third.push_back(GAP_CHAR);
      end
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_reg(input logic idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [7:0] window, input logic [7:0] margin);
      write_reg(REG_NEAR_WINDOW, window);
      write_reg(REG_EDGE_MARGIN, margin);
      read_reg(REG_NEAR_WINDOW);
      read_reg(REG_EDGE_MARGIN);
   endtask

   // stop offering columns and wait for every verdict to come out
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_left != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [7:0] window_set [PHASES];
      logic [7:0] margin_set [PHASES];
      window_set = '{8'd10, 8'd0, 8'd255, 8'd0, 8'd255, 8'd2};
      margin_set = '{8'd4, 8'd0, 8'd255, 8'd255, 8'd0, 8'd1};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_reg(REG_NEAR_WINDOW);
      read_reg(REG_EDGE_MARGIN);

      // directed exons, narrow window and no margin
      set_regs(8'd1, 8'd0);
      load_rows("A---A", "A---A", "CCCCC", "GGGGG");  // clean pass
      send_rows();
      load_rows("An", "AA", "NA", "AA");              // N in reference and species 2
      send_rows();
      load_rows("A---A", "A---A", "AAAAA", "AA-AA");  // species 2/3 gaps differ
      send_rows();
      load_rows("A---A", "A----", "AAAAA", "AAAAA");  // ref/species-1 gap next to run
      send_rows();
      load_rows("A-A", "A-A", "A-A", "A-A");          // all four rows gap together, column dropped
      send_rows();
      load_rows("---A", "---A", "AAAA", "AAAA");      // gap at column zero
      send_rows();
      clear_rows();                                   // extreme bytes, dash-only last
      row_ref    = {8'hFF, GAP_CHAR};
      row_first  = {8'h00, GAP_CHAR};
      row_second = {8'hFF, GAP_CHAR};
      row_third  = {8'h00, GAP_CHAR};
      send_rows();
      settle();

      // random phases across register settings
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1)
            set_regs(8'($urandom_range(0, 12)), 8'($urandom_range(0, 6)));
         else
            set_regs(window_set[p], margin_set[p]);
         quiet = (p % 3 == 2);
         columns_sent = 0;
         while (columns_sent < PHASE_COLUMNS) begin
            build_exon();
            send_rows();
         end
         settle();

         // back-pressure: receiver holds off while short exons keep being offered
         if (p == 1) begin
            quiet = 1'b1;
            hold_request = 1'b1;
            repeat (24) begin
               load_rows("A---AC", "A---AC", "CCCCCC", "GGGGGG");
               send_rows();
            end
            settle();
         end
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("alignment_gap_pattern_check test passed");
      else
         $display("alignment_gap_pattern_check test failed");
      $finish;
   end

endmodule
